// File: hw/rtl/sgs_pkg.sv
// ----------------------------------------------------------------------------
// Sobel gradient stream package
// Shared types, constants and the arctangent table of the angle unit.
// ----------------------------------------------------------------------------
package sgs_pkg;

   localparam int MAX_LINE     = 1024;
   localparam int HEIGHT_LIMIT = 4096;
   localparam int COL_W        = $clog2(MAX_LINE);
   localparam int ROW_W        = $clog2(HEIGHT_LIMIT);
   localparam int WIDTH_W      = 11;
   localparam int HEIGHT_W     = 13;
   localparam int PIX_W        = 8;
   localparam int GRAD_W       = 11;
   localparam int MAG_W        = 15;
   localparam int ANG_W        = 16;
   localparam int SUMSQ_W      = 29;
   localparam int CORD_W       = 30;
   localparam int ACC_W        = 20;
   localparam int ANGLE_STEPS  = 19;
   localparam int STEP_W       = 5;
   localparam int ROOT_BITS    = 15;
   localparam int CSR_IDX_W    = 8;
   localparam int CSR_DATA_W   = 13;
   localparam int RSP_DATA_W   = 72;

   // Register indexes of the configuration port.
   localparam logic [CSR_IDX_W-1:0] REG_IMAGE_WIDTH  = 8'd0;
   localparam logic [CSR_IDX_W-1:0] REG_IMAGE_HEIGHT = 8'd1;

   localparam logic [WIDTH_W-1:0]  WIDTH_RESET  = 11'd640;
   localparam logic [HEIGHT_W-1:0] HEIGHT_RESET = 13'd480;
   localparam logic [ANG_W-1:0]    ANGLE_ZERO_GRAD = 16'd32768;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_WINDOW,
      ST_SQUARE,
      ST_SUM,
      ST_ITER,
      ST_ROUND,
      ST_EMIT
   } sgs_state_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic              capture;
      logic              window;
      logic              square;
      logic              sum;
      logic              iterate;
      logic [STEP_W-1:0] step;
      logic              round;
      logic              emit;
   } sgs_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic interior;
      logic out_free;
   } sgs_status_type;

   // Arctangent of 2^-i in units of 2^-20 turn, rounded.
   function automatic logic [ACC_W-1:0] atan_units(input logic [STEP_W-1:0] step);
      logic [ACC_W-1:0] value;
      unique case (step)
         5'd0:    value = 20'd131072;
         5'd1:    value = 20'd77376;
         5'd2:    value = 20'd40884;
         5'd3:    value = 20'd20753;
         5'd4:    value = 20'd10417;
         5'd5:    value = 20'd5213;
         5'd6:    value = 20'd2607;
         5'd7:    value = 20'd1304;
         5'd8:    value = 20'd652;
         5'd9:    value = 20'd326;
         5'd10:   value = 20'd163;
         5'd11:   value = 20'd81;
         5'd12:   value = 20'd41;
         5'd13:   value = 20'd20;
         5'd14:   value = 20'd10;
         5'd15:   value = 20'd5;
         5'd16:   value = 20'd3;
         5'd17:   value = 20'd1;
         5'd18:   value = 20'd1;
         default: value = 20'd0;
      endcase
      return value;
   endfunction

endpackage

// File: hw/rtl/sgs_controller.sv
// ----------------------------------------------------------------------------
// Sobel gradient stream controller
// Sequences one item through window, square, sum, iterate, round and emit steps.
// ----------------------------------------------------------------------------
module sgs_controller (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_tvalid,
   output logic                    req_tready,
   input  sgs_pkg::sgs_status_type status,
   output sgs_pkg::sgs_cmd_type    cmd
);
   import sgs_pkg::*;

   sgs_state_type     state_ff, state_in;
   logic [STEP_W-1:0] step_ff, step_in;

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:   if (req_tvalid) state_in = ST_WINDOW;
         ST_WINDOW: state_in = status.interior ? ST_SQUARE : ST_IDLE;
         ST_SQUARE: state_in = ST_SUM;
         ST_SUM:    state_in = ST_ITER;
         ST_ITER:   if (step_ff == STEP_W'(ANGLE_STEPS - 1)) state_in = ST_ROUND;
         ST_ROUND:  state_in = ST_EMIT;
         ST_EMIT:   if (status.out_free) state_in = ST_IDLE;
         default:   state_in = ST_IDLE;
      endcase
   end

   // Step counter of the shared iteration state.
   always_comb begin
      step_in = '0;
      if (state_ff == ST_ITER) step_in = step_ff + STEP_W'(1);
   end

   // Outputs.
   always_comb begin
      req_tready  = (state_ff == ST_IDLE);
      cmd         = '0;
      cmd.step    = step_ff;
      cmd.capture = (state_ff == ST_IDLE) && req_tvalid;
      cmd.window  = (state_ff == ST_WINDOW);
      cmd.square  = (state_ff == ST_SQUARE);
      cmd.sum     = (state_ff == ST_SUM);
      cmd.iterate = (state_ff == ST_ITER);
      cmd.round   = (state_ff == ST_ROUND);
      cmd.emit    = (state_ff == ST_EMIT) && status.out_free;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         step_ff  <= '0;
      end else begin
         state_ff <= state_in;
         step_ff  <= step_in;
      end
   end

endmodule

// File: hw/rtl/sgs_datapath.sv
// ----------------------------------------------------------------------------
// Sobel gradient stream datapath
// Line buffers, window, gradients, square root, CORDIC and output register.
// ----------------------------------------------------------------------------
module sgs_datapath (
   input  logic                                  clock,
   input  logic                                  reset,
   input  sgs_pkg::sgs_cmd_type                  cmd,
   output sgs_pkg::sgs_status_type               status,
   input  logic [sgs_pkg::PIX_W-1:0]             pixel,
   input  logic                                  csr_write,
   input  logic [sgs_pkg::CSR_IDX_W-1:0]         csr_index,
   input  logic [sgs_pkg::CSR_DATA_W-1:0]        csr_data,
   output logic                                  rsp_tvalid,
   input  logic                                  rsp_tready,
   output logic [sgs_pkg::RSP_DATA_W-1:0]        rsp_tdata,
   output logic                                  rsp_tlast
);
   import sgs_pkg::*;

   // Configuration and position.
   logic [WIDTH_W-1:0]  width_ff;
   logic [HEIGHT_W-1:0] height_ff;
   logic [WIDTH_W-1:0]  width_eff;
   logic [HEIGHT_W-1:0] height_eff;
   logic [COL_W-1:0]    col_ff, col_in, col_cur, col_pos_ff;
   logic [ROW_W-1:0]    row_ff, row_in, row_cur, row_pos_ff;
   logic [WIDTH_W-1:0]  col_next;
   logic [HEIGHT_W-1:0] row_next;
   logic                col_wrap, row_wrap;

   // Line buffers and window.
   logic [PIX_W-1:0] row_above_mem [MAX_LINE];
   logic [PIX_W-1:0] row_two_above_mem [MAX_LINE];
   logic [PIX_W-1:0] pix_ff, tr_ff, mr_ff;
   logic [PIX_W-1:0] win_ff [6];

   // Arithmetic.
   logic signed [GRAD_W:0]     gx_wide, gy_wide;
   logic signed [GRAD_W-1:0]   gx_ff, gy_ff;
   logic signed [2*GRAD_W-1:0] gx_ext, gy_ext;
   logic                       last_ff;
   logic [2*GRAD_W-1:0]        sqx_ff, sqy_ff;
   logic [SUMSQ_W-1:0]         n_ff;
   logic [ROOT_BITS-1:0]       root_ff, trial;
   logic [2*ROOT_BITS-1:0]     trial_sq, root_sq;
   logic [3:0]                 root_bit;
   logic [MAG_W-1:0]           mag_ff, peak_ff, peak_max;
   logic [SUMSQ_W:0]           rem;
   logic signed [CORD_W-1:0]   x_ff, y_ff, x_sh, y_sh;
   logic signed [CORD_W-1:0]   x0, y0;
   logic [ACC_W-1:0]           acc_ff, acc_sum;
   logic                       zero_ff;
   logic [ANG_W-1:0]           angle;

   // Output register.
   logic                  rsp_valid_ff;
   logic [RSP_DATA_W-1:0] rsp_data_ff;
   logic                  rsp_last_ff;

   // Clamped frame size and current position.
   always_comb begin
      width_eff = width_ff;
      if (width_ff < WIDTH_W'(3)) width_eff = WIDTH_W'(3);
      if (width_ff > WIDTH_W'(MAX_LINE)) width_eff = WIDTH_W'(MAX_LINE);
      height_eff = height_ff;
      if (height_ff < HEIGHT_W'(3)) height_eff = HEIGHT_W'(3);
      if (height_ff > HEIGHT_W'(HEIGHT_LIMIT)) height_eff = HEIGHT_W'(HEIGHT_LIMIT);
      col_cur = ({1'b0, col_ff} >= width_eff) ? '0 : col_ff;
      row_cur = ({1'b0, row_ff} >= height_eff) ? '0 : row_ff;
   end

   // Position advance after the window step.
   always_comb begin
      col_next = {1'b0, col_pos_ff} + WIDTH_W'(1);
      row_next = {1'b0, row_pos_ff} + HEIGHT_W'(1);
      col_wrap = (col_next == width_eff);
      row_wrap = (row_next == height_eff);
      col_in   = col_ff;
      row_in   = row_ff;
      if (cmd.window) begin
         col_in = col_wrap ? '0 : col_next[COL_W-1:0];
         if (col_wrap) row_in = row_wrap ? '0 : row_next[ROW_W-1:0];
      end
      if (csr_write) begin
         col_in = '0;
         row_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= WIDTH_RESET;
         height_ff <= HEIGHT_RESET;
         col_ff    <= '0;
         row_ff    <= '0;
      end else begin
         col_ff <= col_in;
         row_ff <= row_in;
         if (csr_write && csr_index == REG_IMAGE_WIDTH) width_ff <= csr_data[WIDTH_W-1:0];
         if (csr_write && csr_index == REG_IMAGE_HEIGHT) height_ff <= csr_data;
      end
   end

   // Line buffer reads at capture, writes at the window step.
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         tr_ff      <= row_two_above_mem[col_cur];
         mr_ff      <= row_above_mem[col_cur];
         pix_ff     <= pixel;
         col_pos_ff <= col_cur;
         row_pos_ff <= row_cur;
      end
      if (cmd.window) begin
         row_two_above_mem[col_pos_ff] <= mr_ff;
         row_above_mem[col_pos_ff]     <= pix_ff;
      end
   end

   // Sobel sums over the window.
   always_comb begin
      gx_wide = $signed({4'b0, win_ff[0]}) + $signed({3'b0, win_ff[1], 1'b0})
              + $signed({4'b0, win_ff[2]}) - $signed({4'b0, tr_ff})
              - $signed({3'b0, mr_ff, 1'b0}) - $signed({4'b0, pix_ff});
      gy_wide = $signed({4'b0, win_ff[0]}) + $signed({3'b0, win_ff[3], 1'b0})
              + $signed({4'b0, tr_ff}) - $signed({4'b0, win_ff[2]})
              - $signed({3'b0, win_ff[5], 1'b0}) - $signed({4'b0, pix_ff});
   end

   assign status.interior = (row_pos_ff >= ROW_W'(2)) && (col_pos_ff >= COL_W'(2));
   assign status.out_free = !rsp_valid_ff || rsp_tready;

   // Window shift and gradient registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < 6; k++) win_ff[k] <= '0;
      end else if (cmd.window) begin
         win_ff[0] <= win_ff[3];
         win_ff[1] <= win_ff[4];
         win_ff[2] <= win_ff[5];
         win_ff[3] <= tr_ff;
         win_ff[4] <= mr_ff;
         win_ff[5] <= pix_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.window) begin
         gx_ff   <= gx_wide[GRAD_W-1:0];
         gy_ff   <= gy_wide[GRAD_W-1:0];
         last_ff <= col_wrap && row_wrap;
      end
   end

   // Square-root digit step and CORDIC micro-rotation.
   always_comb begin
      gx_ext   = {{GRAD_W{gx_ff[GRAD_W-1]}}, gx_ff};
      gy_ext   = {{GRAD_W{gy_ff[GRAD_W-1]}}, gy_ff};
      root_bit = 4'(ROOT_BITS - 1) - cmd.step[3:0];
      trial    = root_ff | (ROOT_BITS'(1) << root_bit);
      trial_sq = trial * trial;
      root_sq  = root_ff * root_ff;
      rem      = {1'b0, n_ff} - root_sq;
      x_sh     = x_ff >>> cmd.step;
      y_sh     = y_ff >>> cmd.step;
      x0       = CORD_W'(gx_ff) <<< 16;
      y0       = CORD_W'(gy_ff) <<< 16;
      acc_sum  = acc_ff + ACC_W'(1 << 19) + ACC_W'(8);
      angle    = zero_ff ? ANGLE_ZERO_GRAD : acc_sum[ACC_W-1:4];
      peak_max = (mag_ff > peak_ff) ? mag_ff : peak_ff;
   end

   always_ff @(posedge clock) begin
      if (cmd.square) begin
         sqx_ff  <= gx_ext * gx_ext;
         sqy_ff  <= gy_ext * gy_ext;
         zero_ff <= (gx_ff == '0) && (gy_ff == '0);
         if (gx_ff < 0) begin
            x_ff   <= -x0;
            y_ff   <= -y0;
            acc_ff <= ACC_W'(1 << 19);
         end else begin
            x_ff   <= x0;
            y_ff   <= y0;
            acc_ff <= '0;
         end
      end
      if (cmd.sum) begin
         n_ff    <= SUMSQ_W'({sqx_ff + sqy_ff, 8'b0});
         root_ff <= '0;
      end
      if (cmd.iterate) begin
         if (cmd.step < STEP_W'(ROOT_BITS) && trial_sq <= {1'b0, n_ff}) root_ff <= trial;
         if (y_ff > 0) begin
            x_ff   <= x_ff + y_sh;
            y_ff   <= y_ff - x_sh;
            acc_ff <= acc_ff + atan_units(cmd.step);
         end else begin
            x_ff   <= x_ff - y_sh;
            y_ff   <= y_ff + x_sh;
            acc_ff <= acc_ff - atan_units(cmd.step);
         end
      end
      if (cmd.round) begin
         mag_ff <= (rem > {{(SUMSQ_W-ROOT_BITS+1){1'b0}}, root_ff}) ? root_ff + MAG_W'(1)
                                                                    : root_ff;
      end
   end

   // Frame peak and output register.
   always_ff @(posedge clock) begin
      if (reset) begin
         peak_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_write) peak_ff <= '0;
         else if (cmd.emit) peak_ff <= last_ff ? '0 : peak_max;
         if (cmd.emit) rsp_valid_ff <= 1'b1;
         else if (rsp_tready) rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.emit) begin
         rsp_data_ff <= {4'b0, peak_max, angle, mag_ff, gy_ff, gx_ff};
         rsp_last_ff <= last_ff;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tlast  = rsp_last_ff;

endmodule

// File: hw/rtl/sobel_gradient_stream_top.sv
// ----------------------------------------------------------------------------
// Sobel gradient stream top level
// 3x3 Sobel edge detector with magnitude, angle and frame peak per interior pixel.
//
// Channel  Direction  Handshake              Payload
// req      in         req_tvalid/req_tready  pixel
// rsp      out        rsp_tvalid/rsp_tready  gradients, strength, angle, peak
// csr      in         csr_valid/csr_ready    register index and data
//
// An item that makes no result ends after its window step; an interior
// item goes on through square, sum, the 19-step CORDIC that shares its
// iteration with the 15-step square root, round and emit. One item is
// worked at a time. The result register lets the next item enter while
// a result waits; a stalled result holds the controller before its emit
// step. Reset is synchronous; line buffers are not cleared.
// ----------------------------------------------------------------------------
module sobel_gradient_stream_top (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [7:0]                          req_tdata,  // pixel[7:0]
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // grad_x[10:0], grad_y[21:11], edge_strength[36:22], edge_angle[52:37],
   // frame_peak[67:53], zero fill
   output logic [sgs_pkg::RSP_DATA_W-1:0]      rsp_tdata,
   output logic                                rsp_tlast,  // frame_done
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [sgs_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [sgs_pkg::CSR_DATA_W-1:0]      csr_data
);
   import sgs_pkg::*;

   sgs_cmd_type    cmd;
   sgs_status_type status;

   assign csr_ready = 1'b1;

   sgs_controller u_controller (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .status     (status),
      .cmd        (cmd)
   );

   sgs_datapath u_datapath (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .status     (status),
      .pixel      (req_tdata),
      .csr_write  (csr_valid),
      .csr_index  (csr_index),
      .csr_data   (csr_data),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

// File: hw/rtl/sgs_checker.sv
// ----------------------------------------------------------------------------
// Sobel gradient stream checker
// Port-level assertions, bound to the top level.
// ----------------------------------------------------------------------------
module sgs_checker (
   input logic                           clock,
   input logic                           reset,
   input logic                           req_tvalid,
   input logic                           req_tready,
   input logic                           rsp_tvalid,
   input logic                           rsp_tready,
   input logic [sgs_pkg::RSP_DATA_W-1:0] rsp_tdata
);
   import sgs_pkg::*;

   // A waiting result stays offered.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid)
      else $error("result dropped while stalled");

   // One item at a time: the cycle after an accept takes no item.
   assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("item accepted while busy");

   // Reset empties the result register.
   assert property (@(posedge clock) $past(reset) |-> !rsp_tvalid)
      else $error("result offered after reset");

   // The frame peak covers the current strength.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[67:53] >= rsp_tdata[36:22])
      else $error("frame peak below strength");

   // A zero gradient gives the half-turn angle.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[21:0] == '0 |-> rsp_tdata[52:37] == ANGLE_ZERO_GRAD)
      else $error("zero gradient angle wrong");

endmodule

bind sobel_gradient_stream_top sgs_checker u_sgs_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);
